// ===== src/jump_window_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Jump window sequencer assertion macros
// Property shorthands shared by the checker of the jump window sequencer.
// ----------------------------------------------------------------------------
`ifndef JUMP_WINDOW_SEQUENCER_MACROS_SVH
`define JUMP_WINDOW_SEQUENCER_MACROS_SVH

// same-cycle implication
`define JWS_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("jws assertion failed");

// next-cycle implication
`define JWS_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("jws assertion failed");

`endif

// ===== src/jws_pkg.sv =====
// ----------------------------------------------------------------------------
// Jump window sequencer package
// Widths, register indexes, exit causes and the structs passed between units.
// ----------------------------------------------------------------------------
package jws_pkg;

    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned GEAR_W      = 3;
    localparam int unsigned CNT_W       = 10;
    localparam int unsigned LEN_W       = 14;
    localparam int unsigned TICKS_W     = 16;
    localparam int unsigned TGT_W       = 15;

    localparam logic [CFG_IDX_W-1:0] REG_VETO_ALLOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFTOFF_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEG_CHANGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_STEP       = 3'd4;

    localparam logic             RST_VETO_ALLOW        = 1'b1;
    localparam logic [CNT_W-1:0] RST_LIFTOFF_THRESHOLD = 10'd10;
    localparam logic [TICKS_W-1:0] RST_WINDOW_TICKS    = 16'd500;
    localparam logic [LEN_W-1:0] RST_MIN_LEG_CHANGE    = 14'd1500;
    localparam logic [LEN_W-1:0] RST_LENGTH_STEP       = 14'd5000;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_LIFTED = 2'd1,
        CAUSE_SMALL  = 2'd2,
        CAUSE_OK     = 2'd3
    } exit_cause_t;

    typedef struct packed {
        logic               veto_allow;
        logic [CNT_W-1:0]   liftoff_threshold;
        logic [TICKS_W-1:0] window_ticks;
        logic [LEN_W-1:0]   min_leg_change;
        logic [LEN_W-1:0]   length_step;
    } jws_cfg_t;

    typedef struct packed {
        logic              request_level;
        logic              spin_busy;
        logic [GEAR_W-1:0] gear_state;
        logic [CNT_W-1:0]  left_liftoff_count;
        logic [CNT_W-1:0]  right_liftoff_count;
        logic [LEN_W-1:0]  left_leg_length;
        logic [LEN_W-1:0]  right_leg_length;
        logic [LEN_W-1:0]  nominal_target;
    } jws_item_t;

    typedef struct packed {
        logic             jump_active;
        logic             mode_flag;
        exit_cause_t      exit_cause;
        logic [TGT_W-1:0] target_length;
        logic             buzzer_start;
        logic             buzzer_stop;
    } jws_result_t;

endpackage

// ===== src/jws_cfg.sv =====
// ----------------------------------------------------------------------------
// Jump window sequencer configuration registers
// Decodes write requests on the configuration channel into the register set.
// ----------------------------------------------------------------------------
module jws_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jws_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [jws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output jws_pkg::jws_cfg_t                cfg
);
    import jws_pkg::*;

    jws_cfg_t cfg_reg;
    jws_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                REG_VETO_ALLOW:        cfg_next.veto_allow        = cfg_wdata[0];
                REG_LIFTOFF_THRESHOLD: cfg_next.liftoff_threshold = cfg_wdata[CNT_W-1:0];
                REG_WINDOW_TICKS:      cfg_next.window_ticks      = cfg_wdata[TICKS_W-1:0];
                REG_MIN_LEG_CHANGE:    cfg_next.min_leg_change    = cfg_wdata[LEN_W-1:0];
                REG_LENGTH_STEP:       cfg_next.length_step       = cfg_wdata[LEN_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.veto_allow        <= RST_VETO_ALLOW;
            cfg_reg.liftoff_threshold <= RST_LIFTOFF_THRESHOLD;
            cfg_reg.window_ticks      <= RST_WINDOW_TICKS;
            cfg_reg.min_leg_change    <= RST_MIN_LEG_CHANGE;
            cfg_reg.length_step       <= RST_LENGTH_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/jws_in_stage.sv =====
// ----------------------------------------------------------------------------
// Jump window sequencer input stage
// Registers one incoming request and unpacks its fields.
// ----------------------------------------------------------------------------
module jws_in_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [jws_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             item_valid,
    input  logic                             item_ready,
    output jws_pkg::jws_item_t               item
);
    import jws_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    jws_item_t item_reg;
    jws_item_t item_next;
    logic      load;

    assign s_tready   = !valid_reg || item_ready;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_comb begin
        item_next                     = item_reg;
        if (load) begin
            item_next.request_level       = s_tdata[0];
            item_next.spin_busy           = s_tdata[1];
            item_next.gear_state          = s_tdata[4:2];
            item_next.left_liftoff_count  = s_tdata[14:5];
            item_next.right_liftoff_count = s_tdata[24:15];
            item_next.left_leg_length     = s_tdata[38:25];
            item_next.right_leg_length    = s_tdata[52:39];
            item_next.nominal_target      = s_tdata[66:53];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

// ===== src/jws_core.sv =====
// ----------------------------------------------------------------------------
// Jump window sequencer core
// Trigger qualification, latch window, lock and buzzer state, result register.
// ----------------------------------------------------------------------------
module jws_core #(
    parameter int unsigned WINDOW_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jws_pkg::jws_cfg_t     cfg,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  jws_pkg::jws_item_t    item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output jws_pkg::jws_result_t  res
);
    import jws_pkg::*;

    logic                   lock_reg,   lock_next;
    logic                   open_reg,   open_next;
    logic [WINDOW_BITS-1:0] left_reg,   left_next;
    logic [LEN_W-1:0]       lstart_reg, lstart_next;
    logic [LEN_W-1:0]       rstart_reg, rstart_next;
    exit_cause_t            cause_reg,  cause_next;
    logic                   buzzer_reg, buzzer_next;
    logic                   valid_reg,  valid_next;
    jws_result_t            res_reg,    res_next;

    logic                   fire;
    logic                   lock_eff;
    logic                   mode;
    logic                   lifted;
    logic                   raw;
    logic                   open_now;
    logic                   active;
    logic                   short_left;
    logic                   short_right;
    logic [WINDOW_BITS-1:0] left_cur;
    logic [LEN_W-1:0]       lstart_cur;
    logic [LEN_W-1:0]       rstart_cur;

    assign item_ready = !valid_reg || res_ready;
    assign fire       = item_valid && item_ready;
    assign res_valid  = valid_reg;
    assign res        = res_reg;

    always_comb begin
        lock_next   = lock_reg;
        open_next   = open_reg;
        left_next   = left_reg;
        lstart_next = lstart_reg;
        rstart_next = rstart_reg;
        cause_next  = cause_reg;
        buzzer_next = buzzer_reg;
        res_next    = res_reg;

        lock_eff = item.request_level && lock_reg;
        mode     = item.request_level && !lock_eff;
        lifted   = (item.left_liftoff_count >= cfg.liftoff_threshold)
                || (item.right_liftoff_count >= cfg.liftoff_threshold);
        raw      = mode && cfg.veto_allow && !item.spin_busy
                && (item.gear_state == '0) && !lifted;
        open_now = raw && !open_reg;

        left_cur   = open_now ? WINDOW_BITS'(cfg.window_ticks) : left_reg;
        lstart_cur = open_now ? item.left_leg_length  : lstart_reg;
        rstart_cur = open_now ? item.right_leg_length : rstart_reg;

        short_left  = {1'b0, item.left_leg_length}
                    < ({1'b0, lstart_cur} + {1'b0, cfg.min_leg_change});
        short_right = {1'b0, item.right_leg_length}
                    < ({1'b0, rstart_cur} + {1'b0, cfg.min_leg_change});

        if (fire) begin
            lock_next   = lock_eff;
            open_next   = open_reg || raw;
            left_next   = left_cur;
            lstart_next = lstart_cur;
            rstart_next = rstart_cur;
            if (open_now) begin
                cause_next = CAUSE_NONE;
            end
            if (open_reg || raw) begin
                if (lifted) begin
                    cause_next = CAUSE_LIFTED;
                    open_next  = 1'b0;
                    lock_next  = 1'b1;
                    mode       = 1'b0;
                end else if (left_cur <= WINDOW_BITS'(1)) begin
                    left_next  = '0;
                    cause_next = (short_left || short_right) ? CAUSE_SMALL : CAUSE_OK;
                    open_next  = 1'b0;
                    lock_next  = 1'b1;
                    mode       = 1'b0;
                end else begin
                    left_next = left_cur - WINDOW_BITS'(1);
                end
            end
        end

        active = open_next || raw;

        if (fire) begin
            buzzer_next            = active;
            res_next.jump_active   = active;
            res_next.mode_flag     = mode;
            res_next.exit_cause    = cause_next;
            res_next.target_length = active
                ? ({1'b0, item.nominal_target} + {1'b0, cfg.length_step}) : '0;
            res_next.buzzer_start  = active && !buzzer_reg;
            res_next.buzzer_stop   = !active && buzzer_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg   <= 1'b0;
            open_reg   <= 1'b0;
            left_reg   <= '0;
            lstart_reg <= '0;
            rstart_reg <= '0;
            cause_reg  <= CAUSE_NONE;
            buzzer_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            lock_reg   <= lock_next;
            open_reg   <= open_next;
            left_reg   <= left_next;
            lstart_reg <= lstart_next;
            rstart_reg <= rstart_next;
            cause_reg  <= cause_next;
            buzzer_reg <= buzzer_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

// ===== src/jump_window_sequencer.sv =====
// ----------------------------------------------------------------------------
// Jump window sequencer
// Datapath: input register then result register; a request accepted at the
// input register has its result on m_tvalid once the result register loads it.
// Throughput: 1 request per cycle if m_tready is high; single core state update.
// Reset: synchronous, active low; clears window, lock, cause and buzzer state,
// empties both stages and loads the register defaults.
// ----------------------------------------------------------------------------
module jump_window_sequencer #(
    parameter int unsigned WINDOW_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request_level, spin_busy, gear_state, left_liftoff_count,
    // right_liftoff_count, left_leg_length, right_leg_length, nominal_target
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jws_pkg::IN_TDATA_W-1:0]    s_tdata,
    // jump_active, mode_flag, exit_cause, target_length, buzzer_start, buzzer_stop
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jws_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [jws_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [jws_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import jws_pkg::*;

    jws_cfg_t    cfg;
    jws_item_t   item;
    jws_result_t res;
    logic        item_valid;
    logic        item_ready;

    jws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jws_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    jws_core #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {3'b000, res.buzzer_stop, res.buzzer_start, res.target_length,
                      res.exit_cause, res.mode_flag, res.jump_active};

endmodule

// ===== src/jws_checker.sv =====
// ----------------------------------------------------------------------------
// Jump window sequencer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "jump_window_sequencer_macros.svh"

module jws_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [jws_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import jws_pkg::*;

    logic             active;
    logic             bstart;
    logic             bstop;
    logic [TGT_W-1:0] target;

    assign active = m_tdata[0];
    assign target = m_tdata[18:4];
    assign bstart = m_tdata[19];
    assign bstop  = m_tdata[20];

    `JWS_ASSERT_NXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_tvalid)
    `JWS_ASSERT_NXT(a_hold_result, aclk, !aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `JWS_ASSERT_IMP(a_idle_target, aclk, !aresetn, m_tvalid && !active, target == '0)
    `JWS_ASSERT_IMP(a_buzzer_edges, aclk, !aresetn, m_tvalid, (!bstart || active) && (!bstop || !active))

endmodule

bind jump_window_sequencer jws_checker u_jws_checker (.*);
